@@ rtl/core/fba_pkg.sv @@
// Shared types and constants of the frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;

  // Size of the frame bitmap.
  localparam int unsigned NUM_FRAMES = 1024;
  localparam int unsigned NUM_WORDS  = (NUM_FRAMES + 31) / 32;
  localparam int unsigned WORD_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned FRAME_W    = WORD_W + 5;

  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(NUM_WORDS - 1);
  localparam logic [31:0] FRAME_LIMIT = 32'(NUM_FRAMES);
  // Frames of the last word that lie beyond the bitmap are never handed out.
  localparam logic [31:0] TAIL_MASK = 32'hFFFF_FFFF >> (NUM_WORDS * 32 - NUM_FRAMES);

  localparam int unsigned SIZE_LOG2_RESET = 12;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_USED    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SIZE_LOG2 = 1'b0,
    REG_NONE      = 1'b1
  } reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_MODIFY
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/frame_bitmap_allocator_unit.sv @@
// Bitmap page frame allocator: one used/free bit per frame, kept in a word memory.
// Each request passes S_DECODE, then S_READ and S_MODIFY for every bitmap word visited; done is registered.
// Allocate scans words from the lowest.
// Range requests walk their words once, twice when a conflict rolls back.
// One request at a time; busy stays high from accept until done pulses.
// Reset: synchronous; a clearing pass in S_CLEAR zeroes the bitmap word by word.
`timescale 1ns / 1ps
`default_nettype none
module frame_bitmap_allocator_unit
  import fba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] start_address,
  input  wire logic [31:0] end_address,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      frame_address,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration register.
  logic [4:0] size_log2;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (reg_t'(paddr[2]) == REG_SIZE_LOG2);
  assign prdata    = (reg_t'(paddr[2]) == REG_SIZE_LOG2) ? {27'd0, size_log2} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= 5'(SIZE_LOG2_RESET);
    end else if (cfg_write) begin
      size_log2 <= pwdata[4:0];
    end
  end

  // Controller registers.
  state_t              state, state_next;
  kind_t               op, op_next;
  logic                rollback, rollback_next;
  logic [31:0]         first, first_next;
  logic [31:0]         last, last_next;
  logic [WORD_W-1:0]   cur, cur_next;
  logic [WORD_W-1:0]   stop, stop_next;
  logic [WORD_W-1:0]   first_word, first_word_next;
  logic [WORD_W-1:0]   last_word, last_word_next;
  logic [4:0]          first_bit, first_bit_next;
  logic [4:0]          last_bit, last_bit_next;
  logic                done_next;
  logic [1:0]          status_next;
  logic [31:0]         frame_address_next;

  // Bitmap memory.
  logic [31:0]         bitmap [NUM_WORDS];
  logic [31:0]         rd_data;
  logic                mem_we;
  logic [31:0]         mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[cur] <= mem_wdata;
    end
    rd_data <= bitmap[cur];
  end

  // Frames of the current word that the request touches.
  logic [31:0] word_mask;
  always_comb begin
    word_mask = 32'hFFFF_FFFF;
    if (cur == first_word) begin
      word_mask = word_mask & (32'hFFFF_FFFF << first_bit);
    end
    if (cur == last_word) begin
      word_mask = word_mask & (32'hFFFF_FFFF >> (5'd31 - last_bit));
    end
  end

  // Frames of the current word whose start address fits in 32 bits.
  logic [31:0] reach_mask;
  logic [5:0]  part_shift;
  assign part_shift = 6'd32 - (6'd1 << (6'd32 - {1'b0, size_log2}));
  always_comb begin
    if (size_log2 == 5'd0) begin
      reach_mask = 32'hFFFF_FFFF;
    end else if (size_log2 <= 5'd27) begin
      reach_mask = ((32'(cur) >> (5'd27 - size_log2)) == 32'd0) ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      reach_mask = (cur == '0) ? (32'hFFFF_FFFF >> part_shift) : 32'd0;
    end
    if (cur == WORD_LAST) begin
      reach_mask = reach_mask & TAIL_MASK;
    end
  end

  // Lowest free reachable frame in the current word.
  logic [31:0] free_bits;
  logic [4:0]  low_idx;
  logic        any_free;
  assign free_bits = ~rd_data & reach_mask;
  assign any_free  = (free_bits != 32'd0);
  always_comb begin
    low_idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        low_idx = 5'(i);
      end
    end
  end

  logic [31:0] alloc_frame;
  assign alloc_frame = 32'({cur, low_idx});

  // Next state and memory access.
  always_comb begin
    state_next         = state;
    op_next            = op;
    rollback_next      = rollback;
    first_next         = first;
    last_next          = last;
    cur_next           = cur;
    stop_next          = stop;
    first_word_next    = first_word;
    last_word_next     = last_word;
    first_bit_next     = first_bit;
    last_bit_next      = last_bit;
    done_next          = 1'b0;
    status_next        = status;
    frame_address_next = frame_address;
    mem_we             = 1'b0;
    mem_wdata          = 32'd0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cur == WORD_LAST) begin
          cur_next   = '0;
          state_next = S_IDLE;
        end else begin
          cur_next = cur + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_next       = kind_t'(kind);
          first_next    = start_address >> size_log2;
          last_next     = end_address >> size_log2;
          rollback_next = 1'b0;
          state_next    = S_DECODE;
        end
      end

      S_DECODE: begin
        first_word_next = first[FRAME_W-1:5];
        first_bit_next  = first[4:0];
        last_word_next  = last[FRAME_W-1:5];
        last_bit_next   = last[4:0];
        stop_next       = last[FRAME_W-1:5];
        cur_next        = '0;
        frame_address_next = 32'd0;
        case (op)
          KIND_ALLOC: begin
            state_next = S_READ;
          end
          KIND_FREE: begin
            if (first >= FRAME_LIMIT) begin
              done_next   = 1'b1;
              status_next = ST_RANGE;
              state_next  = S_IDLE;
            end else begin
              last_word_next = first[FRAME_W-1:5];
              last_bit_next  = first[4:0];
              stop_next      = first[FRAME_W-1:5];
              cur_next       = first[FRAME_W-1:5];
              state_next     = S_READ;
            end
          end
          default: begin
            if (first > last) begin
              done_next   = 1'b1;
              status_next = ST_OK;
              state_next  = S_IDLE;
            end else if (last >= FRAME_LIMIT) begin
              done_next   = 1'b1;
              status_next = ST_RANGE;
              state_next  = S_IDLE;
            end else begin
              cur_next   = first[FRAME_W-1:5];
              state_next = S_READ;
            end
          end
        endcase
      end

      S_READ: begin
        state_next = S_MODIFY;
      end

      S_MODIFY: begin
        if (op == KIND_ALLOC) begin
          // Claim the lowest free frame, move to the next word, or report that none is free.
          if (any_free) begin
            mem_we             = 1'b1;
            mem_wdata          = rd_data | (32'd1 << low_idx);
            done_next          = 1'b1;
            status_next        = ST_OK;
            frame_address_next = alloc_frame << size_log2;
            state_next         = S_IDLE;
          end else if (cur == WORD_LAST || reach_mask == 32'd0) begin
            done_next   = 1'b1;
            status_next = ST_NO_FREE;
            state_next  = S_IDLE;
          end else begin
            cur_next   = cur + 1'b1;
            state_next = S_READ;
          end
        end else if (op == KIND_USED && !rollback) begin
          // Claim the range word by word; a used frame past the first word starts the rollback.
          if ((rd_data & word_mask) != 32'd0) begin
            if (cur == first_word) begin
              done_next   = 1'b1;
              status_next = ST_CONFLICT;
              state_next  = S_IDLE;
            end else begin
              rollback_next = 1'b1;
              stop_next     = cur - 1'b1;
              cur_next      = first_word;
              state_next    = S_READ;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_data | word_mask;
            if (cur == stop) begin
              done_next   = 1'b1;
              status_next = ST_OK;
              state_next  = S_IDLE;
            end else begin
              cur_next   = cur + 1'b1;
              state_next = S_READ;
            end
          end
        end else begin
          // Release the frames of the range, or undo a partial claim.
          mem_we    = 1'b1;
          mem_wdata = rd_data & ~word_mask;
          if (cur == stop) begin
            done_next   = 1'b1;
            status_next = rollback ? ST_CONFLICT : ST_OK;
            state_next  = S_IDLE;
          end else begin
            cur_next   = cur + 1'b1;
            state_next = S_READ;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      done  <= done_next;
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    op            <= op_next;
    rollback      <= rollback_next;
    first         <= first_next;
    last          <= last_next;
    stop          <= stop_next;
    first_word    <= first_word_next;
    last_word     <= last_word_next;
    first_bit     <= first_bit_next;
    last_bit      <= last_bit_next;
    status        <= status_next;
    frame_address <= frame_address_next;
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/fba_checker.sv @@
// Port-level checks of the frame bitmap allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module fba_checker
  import fba_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [31:0] frame_address
);

  // An accepted word keeps the unit busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("unit not busy after accepting a request");

  // A result ends the request: the unit is free in the same cycle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while unit still busy");

  // Each result follows work on a request.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a request in progress");

  // Results never come in back-to-back cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // A failed request reports a zero address.
  assert property (@(posedge clk) disable iff (rst)
      (done && status != 2'(ST_OK)) |-> (frame_address == 32'd0))
    else $error("address reported with a failure status");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .frame_address (frame_address)
);
`default_nettype wire

@@ verif/frame_bitmap_allocator_unit_test.sv @@
// Self-checking testbench for the frame bitmap allocator: random request words, APB setup.
`timescale 1ns / 1ps
module frame_bitmap_allocator_unit_test;
  import fba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] first_addr;
    logic [31:0] last_addr;
  } frame_request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
  } frame_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = 2'b00;
  logic [31:0] start_address = '0;
  logic [31:0] end_address = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] frame_address;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the bitmap and of the frame size register.
  bit          frame_used [NUM_FRAMES];
  logic [4:0]  size_log2 = 5'(SIZE_LOG2_RESET);

  frame_request_t request_queue[$];
  frame_outcome_t predicted_outcomes[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    idle_left = 0;
  bit             steady = 1'b0;

  frame_bitmap_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .start_address (start_address),
    .end_address   (end_address),
    .done          (done),
    .status        (status),
    .frame_address (frame_address),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Number of frames whose start address fits in 32 bits, capped at the bitmap size.
  function automatic int unsigned reach_count();
    longint unsigned span;
    if (size_log2 == 0) begin
      return NUM_FRAMES;
    end
    span = 64'd1 << (32 - size_log2);
    return (span < NUM_FRAMES) ? int'(span) : NUM_FRAMES;
  endfunction

  // Applies one request to the shadow bitmap and returns the outcome it must produce.
  function automatic frame_outcome_t apply_request(input kind_t k, input logic [31:0] a,
                                                   input logic [31:0] b);
    frame_outcome_t res;
    int unsigned    first, last, reach, f, g;
    bit             hit;
    res.status = ST_OK;
    res.addr = '0;
    first = a >> size_log2;
    last = b >> size_log2;
    hit = 1'b0;
    case (k)
      KIND_ALLOC: begin
        reach = reach_count();
        res.status = ST_NO_FREE;
        for (f = 0; f < reach && !hit; f++) begin
          if (!frame_used[f]) begin
            frame_used[f] = 1'b1;
            res.status = ST_OK;
            res.addr = 32'(64'(f) << size_log2);
            hit = 1'b1;
          end
        end
      end
      KIND_FREE: begin
        if (first >= NUM_FRAMES) begin
          res.status = ST_RANGE;
        end else begin
          frame_used[first] = 1'b0;
        end
      end
      default: begin
        // A reversed range is empty and leaves everything as it is.
        if (first <= last) begin
          if (last >= NUM_FRAMES) begin
            res.status = ST_RANGE;
          end else if (k == KIND_USED) begin
            // On a conflict, only the frames claimed by this request are released.
            for (f = first; f <= last && !hit; f++) begin
              if (frame_used[f]) begin
                for (g = first; g < f; g++) begin
                  frame_used[g] = 1'b0;
                end
                res.status = ST_CONFLICT;
                hit = 1'b1;
              end else begin
                frame_used[f] = 1'b1;
              end
            end
          end else begin
            for (f = first; f <= last; f++) begin
              frame_used[f] = 1'b0;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Any address inside frame f under the current frame size.
  function automatic logic [31:0] addr_in_frame(input int unsigned f);
    logic [63:0] base, spread;
    base = 64'(f) << size_log2;
    spread = 64'($urandom) & ((64'd1 << size_log2) - 64'd1);
    return 32'(base | spread);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic queue_request(input kind_t k, input logic [31:0] a, input logic [31:0] b);
    frame_request_t r;
    r.kind = k;
    r.first_addr = a;
    r.last_addr = b;
    request_queue.push_back(r);
  endtask

  // Random mix, most of it aimed at the low frames where allocations pile up.
  task automatic queue_random_requests(input int unsigned count);
    int unsigned reach, hot, first, last, pick;
    reach = reach_count();
    hot = (reach < 96) ? reach : 96;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      first = $urandom_range(0, hot - 1);
      last = first + $urandom_range(0, 24);
      if (last >= reach) begin
        last = reach - 1;
      end
      if (pick < 35) begin
        queue_request(KIND_ALLOC, $urandom, $urandom);
      end else if (pick < 55) begin
        queue_request(KIND_FREE, addr_in_frame(first), $urandom);
      end else if (pick < 72) begin
        queue_request(KIND_USED, addr_in_frame(first), addr_in_frame(last));
      end else if (pick < 86) begin
        queue_request(KIND_RELEASE, addr_in_frame(first), addr_in_frame(last));
      end else if (pick < 90) begin
        queue_request(pick[0] ? KIND_USED : KIND_RELEASE, addr_in_frame(first),
                      addr_in_frame(reach - 1));
      end else if (pick < 94) begin
        queue_request(pick[0] ? KIND_USED : KIND_RELEASE, addr_in_frame(last),
                      addr_in_frame(first));
      end else begin
        queue_request(kind_t'($urandom_range(1, 3)), $urandom, $urandom);
      end
    end
  endtask

  // Waits until no word is pending, in flight or outstanding and the block is idle.
  task automatic wait_until_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || start || predicted_outcomes.size() != 0 ||
           busy !== 1'b0) begin
      @(negedge clk);
    end
  endtask

  // APB write of the frame size register, issued only while the block is idle.
  task automatic set_frame_size(input logic [4:0] value);
    wait_until_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'({REG_SIZE_LOG2, 2'b00});
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    size_log2 = value;
    @(negedge clk);
  endtask

  // Driver: presents the next request word after a random gap and predicts it on accept.
  always @(posedge clk) begin : driver
    frame_request_t nxt;
    int unsigned    gap;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (start && !busy) begin
      predicted_outcomes.push_back(apply_request(kind_t'(kind), start_address, end_address));
      if ($urandom_range(0, 63) == 0) begin
        steady = !steady;
      end
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap == 0 && request_queue.size() != 0) begin
        nxt = request_queue.pop_front();
        kind <= nxt.kind;
        start_address <= nxt.first_addr;
        end_address <= nxt.last_addr;
      end else begin
        start <= 1'b0;
        idle_left <= gap;
      end
    end else if (!start) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else if (request_queue.size() != 0) begin
        nxt = request_queue.pop_front();
        kind <= nxt.kind;
        start_address <= nxt.first_addr;
        end_address <= nxt.last_addr;
        start <= 1'b1;
      end
    end
  end

  // Monitor: each done strobe is checked against the oldest predicted outcome.
  always @(posedge clk) begin : monitor
    frame_outcome_t want;
    if (!rst && done === 1'b1) begin
      if (predicted_outcomes.size() == 0) begin
        report_mismatch("result word with no request outstanding");
      end else begin
        want = predicted_outcomes.pop_front();
        if (status !== want.status) begin
          report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
        end
        if (frame_address !== want.addr) begin
          report_mismatch($sformatf("frame_address expected %h got %h", want.addr,
                                    frame_address));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // The clearing pass keeps the block busy after reset.
    wait_until_idle();

    // Directed words at the reset frame size of 4 KiB.
    queue_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_FREE, 32'h0000_0FFF, 32'hFFFF_FFFF);
    queue_request(KIND_ALLOC, 32'h1234_5678, 32'h0000_0000);
    queue_request(KIND_USED, 32'h0000_2000, 32'h0000_5FFF);
    queue_request(KIND_USED, 32'h0000_7000, 32'h0000_3000);
    queue_request(KIND_USED, 32'h0002_8000, 32'h0002_DFFF);
    // Conflict in the middle: frames claimed before it must be given back.
    queue_request(KIND_USED, 32'h0002_3000, 32'h0003_2000);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(KIND_USED, 32'h0002_3000, 32'h0002_7FFF);
    queue_request(KIND_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(KIND_USED, 32'h0000_0000, 32'h0040_0000);
    queue_request(KIND_RELEASE, 32'h0000_1000, 32'hFFFF_FFFF);
    queue_request(KIND_RELEASE, 32'hFFFF_F000, 32'h0000_0000);
    queue_request(KIND_RELEASE, 32'h0000_0000, 32'h003F_FFFF);
    queue_request(KIND_USED, 32'h0000_0000, 32'h003F_FFFF);
    queue_request(KIND_ALLOC, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_request(KIND_FREE, 32'h003F_F000, 32'h0000_0000);
    queue_request(KIND_ALLOC, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_request(KIND_USED, 32'h0010_0000, 32'h0010_0FFF);
    queue_request(KIND_RELEASE, 32'h0000_0000, 32'h003F_FFFF);
    queue_request(KIND_USED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random_requests(300);

    // One-byte frames: almost every address lies beyond the bitmap.
    set_frame_size(5'd0);
    queue_request(KIND_FREE, 32'h0000_0400, 32'h0000_0000);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_random_requests(200);

    // Largest frames: only two are reachable, so allocation runs dry fast.
    set_frame_size(5'd31);
    queue_request(KIND_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_random_requests(100);

    set_frame_size(5'd5);
    queue_random_requests(200);

    // Exactly as many reachable frames as the bitmap holds.
    set_frame_size(5'd22);
    queue_random_requests(100);

    set_frame_size(5'd25);
    queue_random_requests(100);

    set_frame_size(5'd12);
    queue_random_requests(100);

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
